/* src/pea_pkg.sv */
// Shared types and constants for the particle Euler / atlas step block.
`timescale 1ns / 1ps
package pea_pkg;

    // Default atlas grid size (rows == columns)
    localparam int ATLAS_ROWS_DEF = 4;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VEL_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_Z       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE_LENGTH = 3'd7;

    localparam logic [30:0] LIFE_RESET = 31'd65536;

    // Euler update steps, in order
    localparam logic [1:0] STEP_VEL_Y = 2'd0;
    localparam logic [1:0] STEP_POS_X = 2'd1;
    localparam logic [1:0] STEP_POS_Y = 2'd2;
    localparam logic [1:0] STEP_POS_Z = 2'd3;

    // Partial products of a 33-bit square
    localparam logic [1:0] PART_HH = 2'd0;
    localparam logic [1:0] PART_HL = 2'd1;
    localparam logic [1:0] PART_LL = 2'd2;

    // Square-root iterations (two radicand bits each)
    localparam int SQRT_STEPS = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQ,
        S_SQRT,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic       add_en;
        logic [1:0] step;
        logic       mag_en;
        logic [1:0] axis;
        logic       sq_mul_en;
        logic [1:0] part;
        logic       sq_acc_en;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       finish;
    } t_cmd;

endpackage

/* src/pea_ctrl.sv */
// Sequencing controller for the particle step: issues datapath commands.
`timescale 1ns / 1ps
module pea_ctrl
    import pea_pkg::*;
#(
    parameter int ATLAS_ROWS = ATLAS_ROWS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);

    localparam int Rows   = (ATLAS_ROWS < 1) ? 1 : ATLAS_ROWS;
    localparam int Stages = Rows * Rows;
    localparam int NumW   = 32 + $clog2(Stages);
    localparam int DvW    = NumW + 16;
    localparam int DcW    = $clog2(DvW + 1);

    t_state r_state, n_state;
    logic [5:0]     r_cnt;
    logic [1:0]     r_axis;
    logic [DcW-1:0] r_dcnt;
    logic           r_oval;
    logic           w_out_free;

    assign w_out_free = !r_oval || !i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_MUL;
            S_MUL:  if (r_cnt == 6'd7) n_state = S_SQ;
            S_SQ:   if (r_cnt == 6'd4 && r_axis == 2'd2) n_state = S_SQRT;
            S_SQRT: if (r_cnt == 6'(SQRT_STEPS)) n_state = S_WAIT;
            S_WAIT: if (r_dcnt == '0 && w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.step = r_cnt[2:1];
        o_cmd.axis = r_axis;
        o_cmd.div_step = (r_dcnt != '0);
        unique case (r_state)
            S_IDLE: o_cmd.load = i_valid;
            S_MUL: begin
                o_cmd.mul_en   = !r_cnt[0];
                o_cmd.add_en   = r_cnt[0];
                o_cmd.div_init = (r_cnt == 6'd0);
            end
            S_SQ: begin
                o_cmd.mag_en    = (r_cnt == 6'd0);
                o_cmd.sq_mul_en = (r_cnt >= 6'd1 && r_cnt <= 6'd3);
                o_cmd.part      = 2'(r_cnt - 6'd1);
                o_cmd.sq_acc_en = (r_cnt >= 6'd2);
            end
            S_SQRT: begin
                o_cmd.sqrt_init = (r_cnt == 6'd0);
                o_cmd.sqrt_step = (r_cnt != 6'd0);
            end
            S_WAIT: o_cmd.finish = (r_dcnt == '0) && w_out_free;
            default: ;
        endcase
    end

    // State, counters and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_axis  <= '0;
            r_dcnt  <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_cnt  <= '0;
                r_axis <= '0;
            end else if (r_state == S_SQ && r_cnt == 6'd4) begin
                r_cnt  <= '0;
                r_axis <= r_axis + 2'd1;
            end else begin
                r_cnt <= r_cnt + 6'd1;
            end
            if (o_cmd.div_init) r_dcnt <= DcW'(DvW);
            else if (r_dcnt != '0) r_dcnt <= r_dcnt - 1'b1;
            if (o_cmd.finish) r_oval <= 1'b1;
            else if (!i_stall) r_oval <= 1'b0;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_oval;

endmodule

/* src/pea_dp.sv */
// Datapath for the particle step: state, multipliers, square root, divider.
`timescale 1ns / 1ps
module pea_dp
    import pea_pkg::*;
#(
    parameter int ATLAS_ROWS = ATLAS_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_restart,
    input  logic [15:0]          i_time_step,
    input  logic signed [31:0]   i_cam_x,
    input  logic signed [31:0]   i_cam_y,
    input  logic signed [31:0]   i_cam_z,
    output logic                 o_alive,
    output logic [31:0]          o_cam_distance,
    output logic [15:0]          o_blend,
    output logic [15:0]          o_first_off_x,
    output logic [15:0]          o_first_off_y,
    output logic [15:0]          o_second_off_x,
    output logic [15:0]          o_second_off_y,
    output logic signed [31:0]   o_out_pos_x,
    output logic signed [31:0]   o_out_pos_y,
    output logic signed [31:0]   o_out_pos_z
);

    localparam int Rows   = (ATLAS_ROWS < 1) ? 1 : ATLAS_ROWS;
    localparam int Stages = Rows * Rows;
    localparam int SW     = (Stages < 2) ? 1 : $clog2(Stages);
    localparam int NumW   = 32 + $clog2(Stages);
    localparam int DvW    = NumW + 16;

    // Configuration registers
    logic [31:0] r_start_pos_x, r_start_pos_y, r_start_pos_z;
    logic [31:0] r_vel_x, r_start_vel_y, r_vel_z, r_gravity;
    logic [30:0] r_life;
    logic [31:0] w_life_eff;

    // Particle state and latched input word
    logic [31:0] r_pos_x, r_pos_y, r_pos_z, r_vel_y, r_elapsed;
    logic [15:0] r_dt;
    logic [31:0] r_cam_x, r_cam_y, r_cam_z;

    // Arithmetic registers
    logic [31:0]  r_prod;
    logic [32:0]  r_mag;
    logic [65:0]  r_sqprod;
    logic [66:0]  r_acc;
    logic [63:0]  r_rad;
    logic [33:0]  r_rem;
    logic [31:0]  r_root;
    logic [DvW-1:0] r_dvd;
    logic [31:0]  r_drem;

    assign w_life_eff = (r_life == '0) ? 32'd1 : {1'b0, r_life};

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos_x <= '0;
            r_start_pos_y <= '0;
            r_start_pos_z <= '0;
            r_vel_x       <= '0;
            r_start_vel_y <= '0;
            r_vel_z       <= '0;
            r_gravity     <= '0;
            r_life        <= LIFE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_POS_X: r_start_pos_x <= i_cfg_data;
                CFG_START_POS_Y: r_start_pos_y <= i_cfg_data;
                CFG_START_POS_Z: r_start_pos_z <= i_cfg_data;
                CFG_VEL_X:       r_vel_x       <= i_cfg_data;
                CFG_START_VEL_Y: r_start_vel_y <= i_cfg_data;
                CFG_VEL_Z:       r_vel_z       <= i_cfg_data;
                CFG_GRAVITY:     r_gravity     <= i_cfg_data;
                CFG_LIFE_LENGTH: r_life        <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Velocity or gravity times dt, floored
    logic [31:0]        w_mul_a;
    logic signed [48:0] w_mul_p;
    always_comb begin
        case (i_cmd.step)
            STEP_VEL_Y: w_mul_a = r_gravity;
            STEP_POS_X: w_mul_a = r_vel_x;
            STEP_POS_Y: w_mul_a = r_vel_y;
            default:    w_mul_a = r_vel_z;
        endcase
        w_mul_p = $signed(w_mul_a) * $signed({1'b0, r_dt});
    end

    // Camera delta magnitude for the selected axis
    logic [31:0]        w_cam_sel, w_pos_sel;
    logic signed [32:0] w_diff;
    always_comb begin
        case (i_cmd.axis)
            2'd0:    begin w_cam_sel = r_cam_x; w_pos_sel = r_pos_x; end
            2'd1:    begin w_cam_sel = r_cam_y; w_pos_sel = r_pos_y; end
            default: begin w_cam_sel = r_cam_z; w_pos_sel = r_pos_z; end
        endcase
        w_diff = $signed({w_cam_sel[31], w_cam_sel}) - $signed({w_pos_sel[31], w_pos_sel});
    end

    // Square partial products of the magnitude
    logic [16:0] w_sq_a, w_sq_b;
    logic [33:0] w_sq_p;
    logic [65:0] w_sq_sh;
    always_comb begin
        case (i_cmd.part)
            PART_HH: begin w_sq_a = r_mag[32:16]; w_sq_b = r_mag[32:16]; end
            PART_HL: begin w_sq_a = r_mag[32:16]; w_sq_b = {1'b0, r_mag[15:0]}; end
            default: begin w_sq_a = {1'b0, r_mag[15:0]}; w_sq_b = {1'b0, r_mag[15:0]}; end
        endcase
        w_sq_p = w_sq_a * w_sq_b;
        case (i_cmd.part)
            PART_HH: w_sq_sh = {w_sq_p, 32'd0};
            PART_HL: w_sq_sh = {15'd0, w_sq_p, 17'd0};
            default: w_sq_sh = {32'd0, w_sq_p};
        endcase
    end

    // Square-root digit step
    logic [33:0] w_rem_sh, w_trial;
    logic        w_sq_ge;
    assign w_rem_sh = {r_rem[31:0], r_rad[63:62]};
    assign w_trial  = {r_root, 2'b01};
    assign w_sq_ge  = (w_rem_sh >= w_trial);

    // Divider bit step
    logic [32:0] w_drem_sh;
    logic        w_dv_ge;
    assign w_drem_sh = {r_drem, r_dvd[DvW-1]};
    assign w_dv_ge   = (w_drem_sh >= {1'b0, w_life_eff});

    // Atlas offset tables
    logic [15:0] w_tab_x [Stages];
    logic [15:0] w_tab_y [Stages];
    for (genvar s = 0; s < Stages; s++) begin : g_tab
        assign w_tab_x[s] = 16'(((s % Rows) * 65536) / Rows);
        assign w_tab_y[s] = 16'(((s / Rows) * 65536) / Rows);
    end

    // Stage index clamp and next stage
    logic [NumW-1:0] w_qidx;
    logic [SW-1:0]   w_idx1, w_idx2;
    always_comb begin
        w_qidx = r_dvd[DvW-1:16];
        if (w_qidx > NumW'(Stages - 1)) w_idx1 = SW'(Stages - 1);
        else                            w_idx1 = w_qidx[SW-1:0];
        if (w_idx1 < SW'(Stages - 1)) w_idx2 = w_idx1 + 1'b1;
        else                          w_idx2 = w_idx1;
    end

    // Saturated elapsed after this step
    logic [32:0] w_esum;
    logic [31:0] w_enew;
    assign w_esum = {1'b0, r_elapsed} + {17'd0, r_dt};
    assign w_enew = w_esum[32] ? 32'hFFFF_FFFF : w_esum[31:0];

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dt    <= i_time_step;
            r_cam_x <= i_cam_x;
            r_cam_y <= i_cam_y;
            r_cam_z <= i_cam_z;
            r_acc   <= '0;
            if (i_restart) begin
                r_pos_x   <= r_start_pos_x;
                r_pos_y   <= r_start_pos_y;
                r_pos_z   <= r_start_pos_z;
                r_vel_y   <= r_start_vel_y;
                r_elapsed <= '0;
            end
        end
        if (i_cmd.mul_en) r_prod <= w_mul_p[47:16];
        if (i_cmd.add_en) begin
            case (i_cmd.step)
                STEP_VEL_Y: r_vel_y <= r_vel_y + r_prod;
                STEP_POS_X: r_pos_x <= r_pos_x + r_prod;
                STEP_POS_Y: r_pos_y <= r_pos_y + r_prod;
                default:    r_pos_z <= r_pos_z + r_prod;
            endcase
        end
        if (i_cmd.mag_en) r_mag <= w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
        if (i_cmd.sq_mul_en) r_sqprod <= w_sq_sh;
        if (i_cmd.sq_acc_en) r_acc <= r_acc + {1'b0, r_sqprod};
        if (i_cmd.sqrt_init) begin
            r_rad  <= r_acc[63:0];
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= w_sq_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[30:0], w_sq_ge};
        end
        if (i_cmd.div_init) begin
            r_dvd  <= {NumW'(r_elapsed) * NumW'(Stages), 16'd0};
            r_drem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[DvW-2:0], w_dv_ge};
            r_drem <= w_dv_ge ? 32'(w_drem_sh - {1'b0, w_life_eff}) : w_drem_sh[31:0];
        end
        if (i_cmd.finish) begin
            r_elapsed      <= w_enew;
            o_alive        <= (w_enew < w_life_eff);
            o_cam_distance <= (r_acc[66:64] != 3'd0) ? 32'hFFFF_FFFF : r_root;
            o_blend        <= r_dvd[15:0];
            o_first_off_x  <= w_tab_x[w_idx1];
            o_first_off_y  <= w_tab_y[w_idx1];
            o_second_off_x <= w_tab_x[w_idx2];
            o_second_off_y <= w_tab_y[w_idx2];
            o_out_pos_x    <= r_pos_x;
            o_out_pos_y    <= r_pos_y;
            o_out_pos_z    <= r_pos_z;
        end
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_pos_z   <= '0;
            r_vel_y   <= '0;
            r_elapsed <= '0;
        end
    end

endmodule

/* src/particle_euler_atlas_step.sv */
// Top level of the particle Euler step with texture-atlas blend.
//
//  channel | direction | handshake               | payload
//  input   | in        | i_valid / o_stall       | restart, time_step, cam_x/y/z
//  result  | out       | o_valid / i_stall       | alive, cam_distance, blend, offsets, pos
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each word is latched on accept, then passes through the Euler products,
// the squared distance and the two-bit-per-cycle square root. The
// bit-serial elapsed/life divider runs alongside; the result is registered
// once both the square root and the divider are done.
// One more word is taken while a finished result waits; it holds in its last
// cycle until the waiting result leaves. Reset is synchronous, active low;
// it clears state and restores config.
`timescale 1ns / 1ps
module particle_euler_atlas_step
    import pea_pkg::*;
#(
    parameter int ATLAS_ROWS = ATLAS_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_restart,
    input  logic [15:0]          i_time_step,
    input  logic signed [31:0]   i_cam_x,
    input  logic signed [31:0]   i_cam_y,
    input  logic signed [31:0]   i_cam_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_alive,
    output logic [31:0]          o_cam_distance,
    output logic [15:0]          o_blend,
    output logic [15:0]          o_first_off_x,
    output logic [15:0]          o_first_off_y,
    output logic [15:0]          o_second_off_x,
    output logic [15:0]          o_second_off_y,
    output logic signed [31:0]   o_out_pos_x,
    output logic signed [31:0]   o_out_pos_y,
    output logic signed [31:0]   o_out_pos_z,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    pea_ctrl #(.ATLAS_ROWS(ATLAS_ROWS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    // Arithmetic and state
    pea_dp #(.ATLAS_ROWS(ATLAS_ROWS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_restart      (i_restart),
        .i_time_step    (i_time_step),
        .i_cam_x        (i_cam_x),
        .i_cam_y        (i_cam_y),
        .i_cam_z        (i_cam_z),
        .o_alive        (o_alive),
        .o_cam_distance (o_cam_distance),
        .o_blend        (o_blend),
        .o_first_off_x  (o_first_off_x),
        .o_first_off_y  (o_first_off_y),
        .o_second_off_x (o_second_off_x),
        .o_second_off_y (o_second_off_y),
        .o_out_pos_x    (o_out_pos_x),
        .o_out_pos_y    (o_out_pos_y),
        .o_out_pos_z    (o_out_pos_z)
    );

endmodule
